FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// An implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rb2d_pkg.sv
// ----------------------------------------------------------------------------
// Rigid body integrator package
// Command and register codes, microcode word format, the control store and
// the saturating Q16.16 helpers of the integrator.
// ----------------------------------------------------------------------------
package rb2d_pkg;

    localparam int unsigned CMD_W  = 3;
    localparam int unsigned Q_W    = 32;
    localparam int unsigned UA_W   = 6;
    localparam int unsigned IN_W   = 136;
    localparam int unsigned OUT_W  = 192;
    localparam int unsigned CFG_IW = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_FORCE     = 3'd0,
        CMD_IMPULSE   = 3'd1,
        CMD_STEP_VEL  = 3'd2,
        CMD_STEP_POS  = 3'd3,
        CMD_CLEAR     = 3'd4,
        CMD_SET_POS   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        BODY_STATIC    = 2'd0,
        BODY_DYNAMIC   = 2'd1,
        BODY_KINEMATIC = 2'd2,
        BODY_BULLET    = 2'd3
    } t_body;

    typedef enum logic [CFG_IW-1:0] {
        CFG_BODY_TYPE  = 3'd0,
        CFG_GRAV_X     = 3'd1,
        CFG_GRAV_Y     = 3'd2,
        CFG_RECIP_MASS = 3'd3,
        CFG_INV_INERT  = 3'd4,
        CFG_TIME_STEP  = 3'd5,
        CFG_LIN_DAMP   = 3'd6,
        CFG_ANG_DAMP   = 3'd7
    } t_cfg_idx;

    // Operand sources for the multiplier and for the adder.
    typedef enum logic [4:0] {
        S_PX, S_PY, S_ANG, S_VX, S_VY, S_W, S_FX, S_FY, S_TQ, S_T0, S_T1,
        S_VEC_X, S_VEC_Y, S_ARM_X, S_ARM_Y, S_GRAV_X, S_GRAV_Y,
        S_IMASS, S_IINERT, S_DT, S_LDAMP, S_ADAMP, S_ZERO
    } t_src;

    // Writeback destinations.
    typedef enum logic [3:0] {
        D_PX, D_PY, D_ANG, D_VX, D_VY, D_W, D_FX, D_FY, D_TQ, D_T0, D_T1, D_NONE
    } t_dst;

    // Writeback operations; a product always refers to the previous step's multiply.
    typedef enum logic [2:0] {
        WB_NONE,   // no write
        WB_QMUL,   // dst = product
        WB_QMAC,   // dst = dst + product
        WB_XLOAD,  // cross accumulator = raw product
        WB_XSUB,   // dst = accumulator - raw product, scaled
        WB_ADD,    // dst = dst + add source
        WB_ZERO,   // dst = 0
        WB_LOAD    // dst = add source
    } t_wb;

    typedef enum logic [2:0] {
        C_NEVER, C_ALWAYS, C_STATIC, C_BULLET, C_KINEMATIC
    } t_cond;

    typedef struct packed {
        t_src            a_sel;
        t_src            b_sel;
        t_wb             wb;
        t_dst            dst;
        t_src            add_sel;
        t_cond           cond;
        logic [UA_W-1:0] target;
    } t_uword;

    localparam logic [UA_W-1:0] UA_END        = 6'd0;
    localparam logic [UA_W-1:0] UA_FORCE      = 6'd1;
    localparam logic [UA_W-1:0] UA_IMPULSE    = 6'd6;
    localparam logic [UA_W-1:0] UA_STEP_VEL   = 6'd12;
    localparam logic [UA_W-1:0] UA_VEL_MAIN   = 6'd17;
    localparam logic [UA_W-1:0] UA_VEL_STATIC = 6'd26;
    localparam logic [UA_W-1:0] UA_STEP_POS   = 6'd29;
    localparam logic [UA_W-1:0] UA_CLEAR      = 6'd34;
    localparam logic [UA_W-1:0] UA_SET_POS    = 6'd37;
    localparam logic [UA_W-1:0] UA_LAST       = 6'd38;

    function automatic t_uword uw(input t_src a, input t_src b, input t_wb w,
                                  input t_dst d, input t_src s, input t_cond c,
                                  input logic [UA_W-1:0] tgt);
        t_uword r;
        r.a_sel   = a;
        r.b_sel   = b;
        r.wb      = w;
        r.dst     = d;
        r.add_sel = s;
        r.cond    = c;
        r.target  = tgt;
        return r;
    endfunction

    function automatic logic [UA_W-1:0] entry_of(input logic [CMD_W-1:0] cmd);
        logic [UA_W-1:0] r;
        unique case (cmd)
            CMD_FORCE:    r = UA_FORCE;
            CMD_IMPULSE:  r = UA_IMPULSE;
            CMD_STEP_VEL: r = UA_STEP_VEL;
            CMD_STEP_POS: r = UA_STEP_POS;
            CMD_CLEAR:    r = UA_CLEAR;
            CMD_SET_POS:  r = UA_SET_POS;
            default:      r = UA_END;
        endcase
        return r;
    endfunction

    // Control store. Each program ends by jumping to the end word, which
    // hands the state to the output register.
    function automatic t_uword rom_word(input logic [UA_W-1:0] a);
        t_uword r;
        unique case (a)
            // apply force at an arm
            6'd1:  r = uw(S_ARM_X, S_VEC_Y, WB_ADD,   D_FX,   S_VEC_X, C_NEVER,  UA_END);
            6'd2:  r = uw(S_ARM_Y, S_VEC_X, WB_XLOAD, D_NONE, S_ZERO,  C_NEVER,  UA_END);
            6'd3:  r = uw(S_ZERO,  S_ZERO,  WB_XSUB,  D_T0,   S_ZERO,  C_NEVER,  UA_END);
            6'd4:  r = uw(S_ZERO,  S_ZERO,  WB_ADD,   D_TQ,   S_T0,    C_NEVER,  UA_END);
            6'd5:  r = uw(S_ZERO,  S_ZERO,  WB_ADD,   D_FY,   S_VEC_Y, C_ALWAYS, UA_END);
            // apply impulse at an arm
            6'd6:  r = uw(S_ARM_X, S_VEC_Y, WB_NONE,  D_NONE, S_ZERO,  C_NEVER,  UA_END);
            6'd7:  r = uw(S_ARM_Y, S_VEC_X, WB_XLOAD, D_NONE, S_ZERO,  C_NEVER,  UA_END);
            6'd8:  r = uw(S_VEC_X, S_IMASS, WB_XSUB,  D_T0,   S_ZERO,  C_NEVER,  UA_END);
            6'd9:  r = uw(S_VEC_Y, S_IMASS, WB_QMAC,  D_VX,   S_ZERO,  C_NEVER,  UA_END);
            6'd10: r = uw(S_IINERT, S_T0,   WB_QMAC,  D_VY,   S_ZERO,  C_NEVER,  UA_END);
            6'd11: r = uw(S_ZERO,  S_ZERO,  WB_QMAC,  D_W,    S_ZERO,  C_ALWAYS, UA_END);
            // velocity step
            6'd12: r = uw(S_ZERO,  S_ZERO,  WB_NONE,  D_NONE, S_ZERO,  C_STATIC,
                          UA_VEL_STATIC);
            6'd13: r = uw(S_ZERO,  S_ZERO,  WB_NONE,  D_NONE, S_ZERO,  C_BULLET, UA_END);
            6'd14: r = uw(S_ZERO,  S_ZERO,  WB_NONE,  D_NONE, S_ZERO,  C_KINEMATIC,
                          UA_VEL_MAIN);
            6'd15: r = uw(S_ZERO,  S_ZERO,  WB_ADD,   D_FX,   S_GRAV_X, C_NEVER, UA_END);
            6'd16: r = uw(S_ZERO,  S_ZERO,  WB_ADD,   D_FY,   S_GRAV_Y, C_NEVER, UA_END);
            6'd17: r = uw(S_IMASS, S_DT,    WB_NONE,  D_NONE, S_ZERO,  C_NEVER,  UA_END);
            6'd18: r = uw(S_IINERT, S_DT,   WB_QMUL,  D_T0,   S_ZERO,  C_NEVER,  UA_END);
            6'd19: r = uw(S_FX,    S_T0,    WB_QMUL,  D_T1,   S_ZERO,  C_NEVER,  UA_END);
            6'd20: r = uw(S_FY,    S_T0,    WB_QMAC,  D_VX,   S_ZERO,  C_NEVER,  UA_END);
            6'd21: r = uw(S_TQ,    S_T1,    WB_QMAC,  D_VY,   S_ZERO,  C_NEVER,  UA_END);
            6'd22: r = uw(S_VX,    S_LDAMP, WB_QMAC,  D_W,    S_ZERO,  C_NEVER,  UA_END);
            6'd23: r = uw(S_VY,    S_LDAMP, WB_QMUL,  D_VX,   S_ZERO,  C_NEVER,  UA_END);
            6'd24: r = uw(S_W,     S_ADAMP, WB_QMUL,  D_VY,   S_ZERO,  C_NEVER,  UA_END);
            6'd25: r = uw(S_ZERO,  S_ZERO,  WB_QMUL,  D_W,    S_ZERO,  C_ALWAYS, UA_END);
            6'd26: r = uw(S_ZERO,  S_ZERO,  WB_ZERO,  D_VX,   S_ZERO,  C_NEVER,  UA_END);
            6'd27: r = uw(S_ZERO,  S_ZERO,  WB_ZERO,  D_VY,   S_ZERO,  C_NEVER,  UA_END);
            6'd28: r = uw(S_ZERO,  S_ZERO,  WB_ZERO,  D_W,    S_ZERO,  C_ALWAYS, UA_END);
            // position step; its tail doubles as the clear-force program
            6'd29: r = uw(S_ZERO,  S_ZERO,  WB_NONE,  D_NONE, S_ZERO,  C_STATIC, UA_END);
            6'd30: r = uw(S_VX,    S_DT,    WB_NONE,  D_NONE, S_ZERO,  C_NEVER,  UA_END);
            6'd31: r = uw(S_VY,    S_DT,    WB_QMAC,  D_PX,   S_ZERO,  C_NEVER,  UA_END);
            6'd32: r = uw(S_W,     S_DT,    WB_QMAC,  D_PY,   S_ZERO,  C_NEVER,  UA_END);
            6'd33: r = uw(S_ZERO,  S_ZERO,  WB_QMAC,  D_ANG,  S_ZERO,  C_NEVER,  UA_END);
            6'd34: r = uw(S_ZERO,  S_ZERO,  WB_ZERO,  D_FX,   S_ZERO,  C_NEVER,  UA_END);
            6'd35: r = uw(S_ZERO,  S_ZERO,  WB_ZERO,  D_FY,   S_ZERO,  C_NEVER,  UA_END);
            6'd36: r = uw(S_ZERO,  S_ZERO,  WB_ZERO,  D_TQ,   S_ZERO,  C_ALWAYS, UA_END);
            // set position
            6'd37: r = uw(S_ZERO,  S_ZERO,  WB_LOAD,  D_PX,   S_VEC_X, C_NEVER,  UA_END);
            6'd38: r = uw(S_ZERO,  S_ZERO,  WB_LOAD,  D_PY,   S_VEC_Y, C_ALWAYS, UA_END);
            default: r = uw(S_ZERO, S_ZERO, WB_NONE,  D_NONE, S_ZERO,  C_NEVER,  UA_END);
        endcase
        return r;
    endfunction

    // Arithmetic shift right by 16 (floor), then saturate to 32 bits.
    function automatic logic signed [Q_W-1:0] sat_shift16(input logic signed [64:0] v);
        logic [48:0] s;
        logic signed [Q_W-1:0] r;
        s = v[64:16];
        if ((s[48:31] == '0) || (s[48:31] == '1)) begin
            r = s[31:0];
        end else if (s[48]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] qadd(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
        logic signed [Q_W:0] s;
        logic signed [Q_W-1:0] r;
        s = {a[Q_W-1], a} + {b[Q_W-1], b};
        if (s[Q_W] == s[Q_W-1]) begin
            r = s[Q_W-1:0];
        end else if (s[Q_W]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/rigid_body_2d_integrator_top.sv
// ----------------------------------------------------------------------------
// 2D rigid body integrator
// Semi-implicit Euler integrator for one body in saturating Q16.16.
// ----------------------------------------------------------------------------
// The block takes one command at a time and answers each with one result
// transaction carrying position, angle, linear velocity and spin after the
// command. A command runs as a short microprogram on a datapath with one
// 32x32 multiplier, registered, whose product is written back in the next
// step while the following multiply starts. A new command is accepted once
// the previous one has handed its result to the output register, even while
// that result still waits there. Configuration writes are taken at any time
// but must only be issued while no command is in progress.

module rigid_body_2d_integrator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command[2:0], vec_x[34:3], vec_y[66:35], arm_x[98:67], arm_y[130:99]
    input  logic [rb2d_pkg::IN_W-1:0]     i_s_axis_tdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // pos_x[31:0], pos_y[63:32], angle[95:64], vel_x[127:96],
    // vel_y[159:128], spin[191:160]
    output logic [rb2d_pkg::OUT_W-1:0]    o_m_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic                          i_cfg_wr_en,
    input  logic [rb2d_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [rb2d_pkg::Q_W-1:0]      i_cfg_wdata
);
    import rb2d_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    // Configuration registers.
    logic [1:0]            r_body_type;
    logic signed [Q_W-1:0] r_grav_x, r_grav_y;
    logic [30:0]           r_recip_mass, r_inv_inertia;
    logic [16:0]           r_time_step, r_lin_damp, r_ang_damp;

    // Body state and scratch registers.
    logic signed [Q_W-1:0] r_pos_x, r_pos_y, r_angle;
    logic signed [Q_W-1:0] r_vel_x, r_vel_y, r_spin;
    logic signed [Q_W-1:0] r_force_x, r_force_y, r_torque;
    logic signed [Q_W-1:0] r_t0, r_t1;

    // Latched command operands.
    logic signed [Q_W-1:0] r_vec_x, r_vec_y, r_arm_x, r_arm_y;

    // Sequencer and datapath pipeline.
    t_state                r_state, n_state;
    logic [UA_W-1:0]       r_upc, n_upc;
    logic signed [63:0]    r_prod;
    logic signed [64:0]    r_xacc;
    logic [OUT_W-1:0]      r_m_data;
    logic                  r_m_valid;

    t_uword                uword;
    t_wb                   wb_op;
    logic                  s_accept, out_free, at_end, jump;
    logic signed [Q_W-1:0] a_val, b_val, add_val, dst_val, mul_q, x_q, wb_val;

    function automatic logic signed [Q_W-1:0] pick(input t_src s,
        input logic signed [Q_W-1:0] px, input logic signed [Q_W-1:0] py,
        input logic signed [Q_W-1:0] an, input logic signed [Q_W-1:0] vx,
        input logic signed [Q_W-1:0] vy, input logic signed [Q_W-1:0] w,
        input logic signed [Q_W-1:0] fx, input logic signed [Q_W-1:0] fy,
        input logic signed [Q_W-1:0] tq, input logic signed [Q_W-1:0] t0,
        input logic signed [Q_W-1:0] t1, input logic signed [Q_W-1:0] ex,
        input logic signed [Q_W-1:0] ey, input logic signed [Q_W-1:0] rx,
        input logic signed [Q_W-1:0] ry, input logic signed [Q_W-1:0] gx,
        input logic signed [Q_W-1:0] gy, input logic [30:0] im,
        input logic [30:0] ii, input logic [16:0] dt, input logic [16:0] ld,
        input logic [16:0] ad);
        logic signed [Q_W-1:0] r;
        unique case (s)
            S_PX:     r = px;
            S_PY:     r = py;
            S_ANG:    r = an;
            S_VX:     r = vx;
            S_VY:     r = vy;
            S_W:      r = w;
            S_FX:     r = fx;
            S_FY:     r = fy;
            S_TQ:     r = tq;
            S_T0:     r = t0;
            S_T1:     r = t1;
            S_VEC_X:  r = ex;
            S_VEC_Y:  r = ey;
            S_ARM_X:  r = rx;
            S_ARM_Y:  r = ry;
            S_GRAV_X: r = gx;
            S_GRAV_Y: r = gy;
            S_IMASS:  r = {1'b0, im};
            S_IINERT: r = {1'b0, ii};
            S_DT:     r = {15'd0, dt};
            S_LDAMP:  r = {15'd0, ld};
            S_ADAMP:  r = {15'd0, ad};
            default:  r = '0;
        endcase
        return r;
    endfunction

    assign uword    = rom_word(r_upc);
    assign at_end   = (r_upc == UA_END);
    assign wb_op    = (r_state == ST_RUN) ? uword.wb : WB_NONE;
    assign out_free = !r_m_valid || i_m_axis_tready;
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    always_comb begin
        a_val = pick(uword.a_sel, r_pos_x, r_pos_y, r_angle, r_vel_x, r_vel_y, r_spin,
                     r_force_x, r_force_y, r_torque, r_t0, r_t1, r_vec_x, r_vec_y,
                     r_arm_x, r_arm_y, r_grav_x, r_grav_y, r_recip_mass, r_inv_inertia,
                     r_time_step, r_lin_damp, r_ang_damp);
        b_val = pick(uword.b_sel, r_pos_x, r_pos_y, r_angle, r_vel_x, r_vel_y, r_spin,
                     r_force_x, r_force_y, r_torque, r_t0, r_t1, r_vec_x, r_vec_y,
                     r_arm_x, r_arm_y, r_grav_x, r_grav_y, r_recip_mass, r_inv_inertia,
                     r_time_step, r_lin_damp, r_ang_damp);
        add_val = pick(uword.add_sel, r_pos_x, r_pos_y, r_angle, r_vel_x, r_vel_y, r_spin,
                       r_force_x, r_force_y, r_torque, r_t0, r_t1, r_vec_x, r_vec_y,
                       r_arm_x, r_arm_y, r_grav_x, r_grav_y, r_recip_mass, r_inv_inertia,
                       r_time_step, r_lin_damp, r_ang_damp);
    end

    always_comb begin
        unique case (uword.dst)
            D_PX:    dst_val = r_pos_x;
            D_PY:    dst_val = r_pos_y;
            D_ANG:   dst_val = r_angle;
            D_VX:    dst_val = r_vel_x;
            D_VY:    dst_val = r_vel_y;
            D_W:     dst_val = r_spin;
            D_FX:    dst_val = r_force_x;
            D_FY:    dst_val = r_force_y;
            D_TQ:    dst_val = r_torque;
            D_T0:    dst_val = r_t0;
            D_T1:    dst_val = r_t1;
            default: dst_val = '0;
        endcase
    end

    // The cross product is formed exactly before the single scaling step.
    assign mul_q = sat_shift16({r_prod[63], r_prod});
    assign x_q   = sat_shift16(r_xacc - {r_prod[63], r_prod});

    always_comb begin
        case (wb_op)
            WB_QMUL: wb_val = mul_q;
            WB_QMAC: wb_val = qadd(dst_val, mul_q);
            WB_XSUB: wb_val = x_q;
            WB_ADD:  wb_val = qadd(dst_val, add_val);
            WB_LOAD: wb_val = add_val;
            default: wb_val = '0;
        endcase
    end

    always_comb begin
        unique case (uword.cond)
            C_ALWAYS:    jump = 1'b1;
            C_STATIC:    jump = (r_body_type == BODY_STATIC);
            C_BULLET:    jump = (r_body_type == BODY_BULLET);
            C_KINEMATIC: jump = (r_body_type == BODY_KINEMATIC);
            default:     jump = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_upc   = r_upc;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_RUN;
                    n_upc   = entry_of(i_s_axis_tdata[CMD_W-1:0]);
                end
            end
            ST_RUN: begin
                if (at_end) begin
                    if (out_free) begin
                        n_state = ST_IDLE;
                    end
                end else if (jump) begin
                    n_upc = uword.target;
                end else begin
                    n_upc = r_upc + 6'd1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_upc     <= UA_END;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
            if (r_state == ST_RUN && at_end && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath pipeline and result register.
    always_ff @(posedge i_clk) begin
        r_prod <= a_val * b_val;
        if (wb_op == WB_XLOAD) begin
            r_xacc <= {r_prod[63], r_prod};
        end
        if (s_accept) begin
            r_vec_x <= i_s_axis_tdata[34:3];
            r_vec_y <= i_s_axis_tdata[66:35];
            r_arm_x <= i_s_axis_tdata[98:67];
            r_arm_y <= i_s_axis_tdata[130:99];
        end
        if (r_state == ST_RUN && at_end && out_free) begin
            r_m_data <= {r_spin, r_vel_y, r_vel_x, r_angle, r_pos_y, r_pos_x};
        end
    end

    // Body state writeback, one destination per step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_angle   <= '0;
            r_vel_x   <= '0;
            r_vel_y   <= '0;
            r_spin    <= '0;
            r_force_x <= '0;
            r_force_y <= '0;
            r_torque  <= '0;
            r_t0      <= '0;
            r_t1      <= '0;
        end else if (wb_op != WB_NONE && wb_op != WB_XLOAD) begin
            unique case (uword.dst)
                D_PX:    r_pos_x   <= wb_val;
                D_PY:    r_pos_y   <= wb_val;
                D_ANG:   r_angle   <= wb_val;
                D_VX:    r_vel_x   <= wb_val;
                D_VY:    r_vel_y   <= wb_val;
                D_W:     r_spin    <= wb_val;
                D_FX:    r_force_x <= wb_val;
                D_FY:    r_force_y <= wb_val;
                D_TQ:    r_torque  <= wb_val;
                D_T0:    r_t0      <= wb_val;
                D_T1:    r_t1      <= wb_val;
                default: ;
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_type   <= BODY_DYNAMIC;
            r_grav_x      <= '0;
            r_grav_y      <= '0;
            r_recip_mass  <= 31'h7FFF_FFFF;
            r_inv_inertia <= '0;
            r_time_step   <= 17'd1092;
            r_lin_damp    <= 17'd65536;
            r_ang_damp    <= 17'd65536;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BODY_TYPE:  r_body_type   <= i_cfg_wdata[1:0];
                CFG_GRAV_X:     r_grav_x      <= i_cfg_wdata;
                CFG_GRAV_Y:     r_grav_y      <= i_cfg_wdata;
                CFG_RECIP_MASS: r_recip_mass  <= i_cfg_wdata[30:0];
                CFG_INV_INERT:  r_inv_inertia <= i_cfg_wdata[30:0];
                CFG_TIME_STEP:  r_time_step   <= i_cfg_wdata[16:0];
                CFG_LIN_DAMP:   r_lin_damp    <= i_cfg_wdata[16:0];
                CFG_ANG_DAMP:   r_ang_damp    <= i_cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_upc_range, r_state == ST_RUN, r_upc <= UA_LAST, "microcode address out of range")
    `ASSERT_IMPLIES(a_xsub_after_xload, wb_op == WB_XSUB, $past(wb_op) == WB_XLOAD, "cross difference without loaded first product")
    `ASSERT_NEXT(a_accept_runs, s_accept, r_state == ST_RUN, "accepted command did not start its program")
    `ASSERT_NEXT(a_end_delivers, r_state == ST_RUN && at_end && out_free, o_m_axis_tvalid && r_state == ST_IDLE, "finished program did not offer its result")

endmodule
